// ===== src/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants of the bilinear texel sampler
// Lane layout of a texel word, multiplier operand widths, register
// indexes and the state codes of the sample sequencer.
// ----------------------------------------------------------------------------
package bts_pkg;

	// A texel word holds four Q4.12 channels: red in the lowest lane.
	localparam int LANES  = 4;
	localparam int LANE_W = 16;
	localparam int WORD_W = LANES * LANE_W;

	// Shared multiplier: signed operands and full-width product.
	localparam int OP_W   = 18;
	localparam int PROD_W = 2 * OP_W;

	// Accumulator of the vertical blend, wide enough for sum < 2^48.
	localparam int ACC_W = 50;

	// Fixed-point constants.
	localparam logic [LANE_W-1:0] ONE_Q412   = 16'd4096;
	localparam logic signed [PROD_W-1:0] HALF_TEXEL = 36'sd32768;
	localparam logic signed [PROD_W-1:0] EDGE_LIMIT = 36'sd32834;

	// Register indexes, taken from byte address bits 3:2.
	localparam logic [1:0] REG_MAP_WIDTH     = 2'd0;
	localparam logic [1:0] REG_MAP_HEIGHT    = 2'd1;
	localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

	// Action codes of an input item.
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Write request to the texel memory (address travels on its own).
	typedef struct packed {
		logic              en;
		logic [LANES-1:0]  lanes;
		logic [WORD_W-1:0] data;
	} wr_req_t;

	// Sample sequencer states.
	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_LOC_X = 13'b0000000000010,
		S_LOC_Y = 13'b0000000000100,
		S_LOC_W = 13'b0000000001000,
		S_FETCH = 13'b0000000010000,
		S_C_UP  = 13'b0000000100000,
		S_C_DN  = 13'b0000001000000,
		S_C_DIF = 13'b0000010000000,
		S_C_SUB = 13'b0000100000000,
		S_C_M1  = 13'b0001000000000,
		S_C_M2  = 13'b0010000000000,
		S_C_ACC = 13'b0100000000000,
		S_C_OUT = 13'b1000000000000
	} state_t;

endpackage

// ===== src/bilinear_texel_sampler.sv =====
// ----------------------------------------------------------------------------
// bilinear_texel_sampler: bilinear lightmap sampler with clamp to edge
// Stores four-channel Q4.12 texels and blends the four neighbours of a
// Q2.16 sample point, all multiplications on one shared multiplier.
// ----------------------------------------------------------------------------
//
//  channel   handshake                     payload
//  -------   ---------------------------   --------------------------------
//  config    psel/penable/pwrite, pready   paddr, pwdata, prdata
//  input     start while busy is low       action, texel_x/y, *_in, u/v
//  result    done, one cycle               red/green/blue/alpha_out
//
// A write item is stored at its accepting edge and busy stays low.
// A sample item keeps busy high until its result: the sequencer locates x
// and y, reads the four neighbours from the single read port, and runs
// each channel through the blend states on the shared multiplier.
// done is high when busy is already low again.
// Reset sets the configuration defaults and clears the sequencer, not the
// datapath registers or the store. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module bilinear_texel_sampler #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [6:0]  texel_x,
	input  logic [6:0]  texel_y,
	input  logic [15:0] red_in,
	input  logic [15:0] green_in,
	input  logic [15:0] blue_in,
	input  logic [15:0] alpha_in,
	input  logic signed [17:0] u_coord,
	input  logic signed [17:0] v_coord,
	// result items
	output logic        done,
	output logic [15:0] red_out,
	output logic [15:0] green_out,
	output logic [15:0] blue_out,
	output logic [15:0] alpha_out
);
	import bts_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WCAP  = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
	localparam int HCAP  = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;

	typedef struct packed {
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [15:0] frac;
	} loc_t;

	// Configuration registers.
	logic [7:0] map_width_q;
	logic [7:0] map_height_q;
	logic [2:0] channel_count_q;

	// Sequencer and datapath registers.
	state_t                   state_q;
	logic [2:0]               nb_q;
	logic [1:0]               ch_q;
	logic signed [OP_W-1:0]   u_q;
	logic signed [OP_W-1:0]   v_q;
	loc_t                     lx_q;
	loc_t                     ly_q;
	logic [WORD_W-1:0]        tex_q [LANES];
	logic [31:0]              up_q;
	logic [31:0]              dn_q;
	logic [32:0]              diff_q;
	logic [ACC_W-1:0]         acc_q;
	logic [LANE_W-1:0]        res_q [LANES];
	logic                     done_q;

	// Combinational signals.
	logic [7:0]               eff_w;
	logic [7:0]               eff_h;
	logic [2:0]               nch;
	logic                     accept;
	logic                     cfg_wr;
	wr_req_t                  wr;
	logic [AW-1:0]            waddr;
	logic                     re;
	logic [AW-1:0]            raddr;
	logic [WORD_W-1:0]        rdata;
	logic signed [OP_W-1:0]   op_a;
	logic signed [OP_W-1:0]   op_b;
	logic signed [PROD_W-1:0] prod;
	logic [LANE_W-1:0]        cval [LANES];
	logic [16:0]              dif_top;
	logic [16:0]              dif_bot;
	logic [ACC_W-1:0]         rnd;
	logic [LANE_W-1:0]        rsat;

	// Store address of a texel.
	function automatic logic [AW-1:0] addr_of(input logic [7:0] x, input logic [7:0] y);
		return AW'(32'(y) * MAX_WIDTH + 32'(x));
	endfunction

	// Neighbour pair and weight of one coordinate from p = c * size.
	function automatic loc_t locate(input logic signed [PROD_W-1:0] p,
	                                input logic [7:0] size);
		loc_t                     l;
		logic signed [PROD_W-1:0] limit;
		logic signed [PROD_W-1:0] d;
		limit = $signed({12'b0, size, 16'b0}) - EDGE_LIMIT;
		d     = p - HALF_TEXEL;
		if (p < EDGE_LIMIT) begin
			l = '0;
		end else if (p > limit) begin
			l.lo   = size - 8'd1;
			l.hi   = size - 8'd1;
			l.frac = '0;
		end else begin
			l.lo   = d[23:16];
			l.hi   = d[23:16] + 8'd1;
			l.frac = d[15:0];
		end
		return l;
	endfunction

	// Sizes and channel count as they take effect.
	always_comb begin
		if (map_width_q == 8'd0) begin
			eff_w = 8'd1;
		end else if (map_width_q > 8'(WCAP)) begin
			eff_w = 8'(WCAP);
		end else begin
			eff_w = map_width_q;
		end
		if (map_height_q == 8'd0) begin
			eff_h = 8'd1;
		end else if (map_height_q > 8'(HCAP)) begin
			eff_h = 8'(HCAP);
		end else begin
			eff_h = map_height_q;
		end
		nch = (channel_count_q > 3'd4) ? 3'd4 : channel_count_q;
	end

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q     <= 8'd128;
			map_height_q    <= 8'd128;
			channel_count_q <= 3'd4;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MAP_WIDTH:     map_width_q     <= pwdata[7:0];
				REG_MAP_HEIGHT:    map_height_q    <= pwdata[7:0];
				REG_CHANNEL_COUNT: channel_count_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MAP_WIDTH:     prdata = {24'b0, map_width_q};
			REG_MAP_HEIGHT:    prdata = {24'b0, map_height_q};
			REG_CHANNEL_COUNT: prdata = {29'b0, channel_count_q};
			default:           prdata = '0;
		endcase
	end

	// Item acceptance and the texel write, done in the accepting cycle.
	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		wr.en    = accept && (action == ACT_WRITE)
		           && ({1'b0, texel_x} < eff_w) && ({1'b0, texel_y} < eff_h);
		for (int i = 0; i < LANES; i++) begin
			wr.lanes[i] = (3'(i) < nch);
		end
		wr.data  = {alpha_in, blue_in, green_in, red_in};
		waddr    = addr_of({1'b0, texel_x}, {1'b0, texel_y});
	end

	// Neighbour reads: bit 0 of the counter picks the column, bit 1 the row.
	assign re    = (state_q == S_FETCH) && (nb_q != 3'd4);
	assign raddr = addr_of(nb_q[0] ? lx_q.hi : lx_q.lo, nb_q[1] ? ly_q.hi : ly_q.lo);

	bts_texel_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.wr    (wr),
		.waddr (waddr),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Channel values of the four neighbours; missing channels read as one.
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			cval[k] = ({1'b0, ch_q} >= nch) ? ONE_Q412 : tex_q[k][{ch_q, 4'b0} +: LANE_W];
		end
		dif_top = {1'b0, cval[1]} - {1'b0, cval[0]};
		dif_bot = {1'b0, cval[3]} - {1'b0, cval[2]};
	end

	// Multiplier operands chosen by the sequencer.
	always_comb begin
		case (state_q)
			S_LOC_X: begin
				op_a = u_q;
				op_b = $signed({10'b0, eff_w});
			end
			S_LOC_Y: begin
				op_a = v_q;
				op_b = $signed({10'b0, eff_h});
			end
			S_C_UP: begin
				op_a = $signed({dif_top[16], dif_top});
				op_b = $signed({2'b0, lx_q.frac});
			end
			S_C_DN: begin
				op_a = $signed({dif_bot[16], dif_bot});
				op_b = $signed({2'b0, lx_q.frac});
			end
			S_C_M1: begin
				op_a = $signed({2'b0, diff_q[15:0]});
				op_b = $signed({2'b0, ly_q.frac});
			end
			S_C_M2: begin
				op_a = $signed({diff_q[32], diff_q[32:16]});
				op_b = $signed({2'b0, ly_q.frac});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	bts_mult u_mult (
		.clk  (clk),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	// Rounding half up and saturation of the finished sum.
	always_comb begin
		rnd  = acc_q + {18'b0, 1'b1, 31'b0};
		rsat = (rnd[ACC_W-1:48] != '0) ? 16'hFFFF : rnd[47:32];
	end

	// Sample sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nb_q    <= '0;
			ch_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && (action == ACT_SAMPLE)) begin
						state_q <= S_LOC_X;
					end
				end
				S_LOC_X: state_q <= S_LOC_Y;
				S_LOC_Y: state_q <= S_LOC_W;
				S_LOC_W: begin
					nb_q    <= '0;
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					if (nb_q == 3'd4) begin
						ch_q    <= '0;
						state_q <= S_C_UP;
					end else begin
						nb_q <= nb_q + 3'd1;
					end
				end
				S_C_UP:  state_q <= S_C_DN;
				S_C_DN:  state_q <= S_C_DIF;
				S_C_DIF: state_q <= S_C_SUB;
				S_C_SUB: state_q <= S_C_M1;
				S_C_M1:  state_q <= S_C_M2;
				S_C_M2:  state_q <= S_C_ACC;
				S_C_ACC: state_q <= S_C_OUT;
				S_C_OUT: begin
					if (ch_q == 2'd3) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= S_C_UP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the sample.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					u_q <= u_coord;
					v_q <= v_coord;
				end
			end
			S_LOC_Y: lx_q <= locate(prod, eff_w);
			S_LOC_W: ly_q <= locate(prod, eff_h);
			S_FETCH: begin
				if (nb_q != 3'd0) begin
					tex_q[nb_q[1:0] - 2'd1] <= rdata;
				end
			end
			// Horizontal blend: up = a * 2^16 + (b - a) * fx.
			S_C_DN:  up_q <= 32'(PROD_W'({cval[0], 16'b0}) + prod);
			S_C_DIF: dn_q <= 32'(PROD_W'({cval[2], 16'b0}) + prod);
			// Vertical blend: sum = up * 2^16 + (dn - up) * fy, in two halves.
			S_C_SUB: begin
				diff_q <= {1'b0, dn_q} - {1'b0, up_q};
				acc_q  <= {2'b0, up_q, 16'b0};
			end
			S_C_M2:  acc_q <= acc_q + {18'b0, prod[31:0]};
			S_C_ACC: acc_q <= acc_q + {prod[33:0], 16'b0};
			S_C_OUT: res_q[ch_q] <= rsat;
			default: ;
		endcase
	end

	assign done      = done_q;
	assign red_out   = res_q[0];
	assign green_out = res_q[1];
	assign blue_out  = res_q[2];
	assign alpha_out = res_q[3];

endmodule

// ===== src/bts_texel_mem.sv =====
// ----------------------------------------------------------------------------
// bts_texel_mem: texel store
// One write port with per-channel lane enables, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bts_texel_mem #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                  clk,
	input  bts_pkg::wr_req_t      wr,
	input  logic [AW-1:0]         waddr,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [bts_pkg::WORD_W-1:0] rdata
);
	import bts_pkg::*;

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	// Only the enabled lanes of an entry are written.
	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			if (wr.en && wr.lanes[i]) begin
				mem_q[waddr][i*LANE_W +: LANE_W] <= wr.data[i*LANE_W +: LANE_W];
			end
		end
	end

	// Registered read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/bts_mult.sv =====
// ----------------------------------------------------------------------------
// bts_mult: shared signed multiplier
// Takes two 18-bit signed operands and registers the 36-bit product.
// ----------------------------------------------------------------------------
module bts_mult (
	input  logic                               clk,
	input  logic signed [bts_pkg::OP_W-1:0]    op_a,
	input  logic signed [bts_pkg::OP_W-1:0]    op_b,
	output logic signed [bts_pkg::PROD_W-1:0]  prod
);
	import bts_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	// The product is registered: it is ready in the cycle after the operands.
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

// ===== src/bts_checker.sv =====
// ----------------------------------------------------------------------------
// bts_checker: port-level checks of the bilinear texel sampler
// Watches the item handshake and the result strobe, bound to the top level.
// ----------------------------------------------------------------------------
module bts_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic action,
	input logic done
);
	import bts_pkg::*;

	// A sample item keeps the block busy in the next cycle.
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_SAMPLE)) |=> busy)
		else $error("sample item did not make the block busy");

	// A write item finishes at once and leaves the block ready.
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_WRITE)) |=> !busy)
		else $error("write item kept the block busy");

	// A result ends a sample: the block was busy and is ready now.
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe outside the end of a sample");

	// The strobe lasts one cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

endmodule

bind bilinear_texel_sampler bts_checker u_bts_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.action (action),
	.done   (done)
);
